>>> sv/terminal_line_editor_history_core_assert.svh
// Assertion macros shared by the line editor checker.
// Depends on nothing; include once per file that asserts.
`ifndef TERMINAL_LINE_EDITOR_HISTORY_CORE_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_HISTORY_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define TLE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define TLE_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> sv/tleh_pkg.sv
// Package for the terminal line editor: sizes, key codes, payload types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package tleh_pkg;
  localparam int LineLen   = 40;
  localparam int MaxChars  = LineLen - 2;
  localparam int HistDepth = 5;
  localparam int SW        = $clog2(HistDepth);
  localparam int HAW       = $clog2(HistDepth * LineLen);

  localparam logic [1:0] REQ_KEY    = 2'd0;
  localparam logic [1:0] REQ_ACCEPT = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [7:0] KEY_BKSPC   = 8'd8;
  localparam logic [7:0] KEY_DEL     = 8'd127;
  localparam logic [7:0] KEY_ENTER   = 8'd13;
  localparam logic [7:0] KEY_ESC     = 8'd27;
  localparam logic [7:0] KEY_BRACKET = 8'd91;
  localparam logic [7:0] KEY_UP      = 8'd65;
  localparam logic [7:0] KEY_DOWN    = 8'd66;
  localparam logic [7:0] KEY_RIGHT   = 8'd67;
  localparam logic [7:0] KEY_LEFT    = 8'd68;
  localparam logic [7:0] KEY_CTRL_E  = 8'h05;
  localparam logic [7:0] KEY_CTRL_I  = 8'h09;
  localparam logic [7:0] KEY_CTRL_L  = 8'h0C;
  localparam logic [7:0] KEY_CTRL_X  = 8'h18;
  localparam logic [7:0] KEY_CTRL_Z  = 8'h1A;
  localparam logic [7:0] KEY_PR_LO   = 8'h20;
  localparam logic [7:0] KEY_PR_HI   = 8'h7E;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] key_byte;
  } tleh_in_t;

  typedef struct packed {
    logic       line_ready;
    logic [7:0] out_char;
    logic [5:0] char_pos;
    logic       last;
    logic [5:0] line_length;
    logic [5:0] cursor_pos;
    logic       insert_on;
    logic [2:0] history_back;
  } tleh_out_t;

  // Memory port bundle from controller to one RAM.
  typedef struct packed {
    logic           we;
    logic [HAW-1:0] waddr;
    logic [7:0]     wdata;
    logic [HAW-1:0] raddr;
  } tleh_mem_t;
endpackage
`default_nettype wire

>>> sv/tleh_ram.sv
// One-write one-read synchronous character RAM, read data registered.
// Depends on tleh_pkg for the port bundle.
`default_nettype none
module tleh_ram #(
  parameter int Depth = 200
) (
  input  wire logic               clk,
  input  wire tleh_pkg::tleh_mem_t port,
  output      logic [7:0]          rdata
);
  logic [7:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr[$clog2(Depth)-1:0]] <= port.wdata;
    end
    rdata <= mem[port.raddr[$clog2(Depth)-1:0]];
  end
endmodule
`default_nettype wire

>>> sv/tleh_ctrl.sv
// Sequencer for the line editor: decodes items and walks the RAMs.
// Depends on tleh_pkg; drives the edit-line RAM and the history RAM.
`default_nettype none
module tleh_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire tleh_pkg::tleh_in_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      tleh_pkg::tleh_out_t out_data,
  output      tleh_pkg::tleh_mem_t ep,
  input  wire logic [7:0]          erd,
  output      tleh_pkg::tleh_mem_t hp,
  input  wire logic [7:0]          hrd
);
  localparam int SW  = tleh_pkg::SW;
  localparam int HAW = tleh_pkg::HAW;
  localparam logic [5:0] MAXC = 6'(tleh_pkg::MaxChars);
  localparam logic [SW-1:0] LASTS = SW'(tleh_pkg::HistDepth - 1);
  localparam logic [2:0] DEPTH3 = 3'(tleh_pkg::HistDepth);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SHU  = 4'd1;  // shift tail up
  localparam logic [3:0] S_SHD  = 4'd2;  // shift tail down
  localparam logic [3:0] S_LOAD = 4'd3;  // history to edit line
  localparam logic [3:0] S_CMP  = 4'd4;  // compare with last stored
  localparam logic [3:0] S_STO  = 4'd5;  // edit line to history
  localparam logic [3:0] S_EMIT = 4'd6;  // read chars for Enter
  localparam logic [3:0] S_OUT  = 4'd7;  // hand out status result
  localparam logic [3:0] S_EOUT = 4'd8;  // Enter char result waiting

  logic [3:0] st_r, st_nxt;
  logic [5:0] cnt_r, cnt_nxt, cur_r, cur_nxt;
  logic ins_r, ins_nxt, esc_r, esc_nxt, brk_r, brk_nxt;
  logic [SW-1:0] put_r, put_nxt, get_r, get_nxt;
  logic [2:0] back_r, back_nxt;
  logic [5:0] hlen_r [tleh_pkg::HistDepth];
  logic [5:0] i_r, i_nxt, end_r, end_nxt;   // walk index and bound
  logic       ph_r, ph_nxt;                 // read issued last cycle
  logic [7:0] ch_r, ch_nxt;
  logic       same_r, same_nxt;
  logic       hwr;
  logic [SW-1:0] hws;
  logic [5:0] hwl;
  logic       ov_r, ov_nxt;
  tleh_pkg::tleh_out_t od_r, od_nxt;

  function automatic logic [HAW-1:0] haddr(input logic [SW-1:0] s, input logic [5:0] i);
    haddr = HAW'(s) * HAW'(tleh_pkg::LineLen) + HAW'(i);
  endfunction

  function automatic logic [SW-1:0] sdec(input logic [SW-1:0] s);
    sdec = (s == '0) ? LASTS : s - 1'b1;
  endfunction
  function automatic logic [SW-1:0] sinc(input logic [SW-1:0] s);
    sinc = (s == LASTS) ? '0 : s + 1'b1;
  endfunction

  assign in_ready  = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // Sequencer next state.
  always_comb begin
    logic [7:0] k;
    logic       enter;
    logic       hist;
    logic [SW-1:0] g;
    logic [SW-1:0] pv;
    k = in_data.key_byte;
    enter = 1'b0;
    hist = 1'b0;
    g = get_r;
    pv = sdec(put_r);
    st_nxt = st_r; cnt_nxt = cnt_r; cur_nxt = cur_r; ins_nxt = ins_r;
    esc_nxt = esc_r; brk_nxt = brk_r; put_nxt = put_r; get_nxt = get_r;
    back_nxt = back_r; i_nxt = i_r; end_nxt = end_r; ph_nxt = 1'b0;
    ch_nxt = ch_r; same_nxt = same_r; ov_nxt = ov_r; od_nxt = od_r;
    hwr = 1'b0; hws = put_r; hwl = cnt_r;
    ep = '0; hp = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid && !ov_r) begin
          st_nxt = S_OUT;
          case (in_data.req_type)
            tleh_pkg::REQ_KEY: begin
              if (esc_r && brk_r) begin
                esc_nxt = 1'b0; brk_nxt = 1'b0;
                case (k)
                  tleh_pkg::KEY_UP: if (back_r < DEPTH3) begin
                    g = sdec(get_r); hist = 1'b1; back_nxt = back_r + 1'b1;
                  end
                  tleh_pkg::KEY_DOWN: if (back_r != 3'd0) begin
                    g = sinc(get_r); hist = 1'b1; back_nxt = back_r - 1'b1;
                  end
                  tleh_pkg::KEY_RIGHT: if (cur_r < cnt_r) cur_nxt = cur_r + 1'b1;
                  tleh_pkg::KEY_LEFT:  if (cur_r != 6'd0) cur_nxt = cur_r - 1'b1;
                  default: ;
                endcase
                get_nxt = g;
                if (hist && hlen_r[g] != 6'd0) begin
                  st_nxt = S_LOAD; i_nxt = '0;
                  end_nxt = (hlen_r[g] > MAXC) ? MAXC : hlen_r[g];
                end
              end else if (esc_r && k == tleh_pkg::KEY_BRACKET) begin
                brk_nxt = 1'b1;
              end else begin
                logic [5:0] c, u;
                c = cnt_r; u = cur_r;
                if (esc_r) begin
                  esc_nxt = 1'b0; brk_nxt = 1'b0; c = '0; u = '0;
                end
                cnt_nxt = c; cur_nxt = u;
                case (k)
                  tleh_pkg::KEY_ESC: begin esc_nxt = 1'b1; brk_nxt = 1'b0; end
                  tleh_pkg::KEY_ENTER: enter = 1'b1;
                  tleh_pkg::KEY_DEL: if (c != 6'd0 && u < c) begin
                    i_nxt = u; cnt_nxt = c - 1'b1; end_nxt = c - 1'b1;
                    st_nxt = S_SHD;
                  end
                  tleh_pkg::KEY_BKSPC: if (u != 6'd0 && c != 6'd0) begin
                    i_nxt = u - 1'b1; cnt_nxt = c - 1'b1; cur_nxt = u - 1'b1;
                    end_nxt = c - 1'b1; st_nxt = S_SHD;
                  end
                  tleh_pkg::KEY_CTRL_E: cnt_nxt = u;
                  tleh_pkg::KEY_CTRL_I: ins_nxt = ~ins_r;
                  tleh_pkg::KEY_CTRL_L: begin cnt_nxt = '0; cur_nxt = '0; end
                  tleh_pkg::KEY_CTRL_Z: cur_nxt = '0;
                  tleh_pkg::KEY_CTRL_X: cur_nxt = c;
                  default: if (k >= tleh_pkg::KEY_PR_LO && k < tleh_pkg::KEY_PR_HI) begin
                    ch_nxt = k;
                    if (u >= c) begin
                      if (c < MAXC) begin
                        ep.we = 1'b1; ep.waddr = HAW'(u); ep.wdata = k;
                        cnt_nxt = c + 1'b1; cur_nxt = u + 1'b1;
                      end
                    end else if (ins_r && c < MAXC) begin
                      i_nxt = c; end_nxt = u; cnt_nxt = c + 1'b1;
                      cur_nxt = u + 1'b1; st_nxt = S_SHU;
                    end else begin
                      ep.we = 1'b1; ep.waddr = HAW'(u); ep.wdata = k;
                      cur_nxt = u + 1'b1;
                    end
                  end
                endcase
                if (enter) begin
                  if (c == 6'd0) begin
                    st_nxt = S_OUT;
                  end else begin
                    st_nxt = S_EMIT; i_nxt = '0; end_nxt = c;
                  end
                end
              end
            end
            tleh_pkg::REQ_ACCEPT: begin
              same_nxt = (hlen_r[pv] == cnt_r);
              i_nxt = '0; end_nxt = cnt_r; st_nxt = S_CMP;
            end
            tleh_pkg::REQ_CLEAR: begin cnt_nxt = '0; cur_nxt = '0; end
            default: ;
          endcase
          od_nxt = '0;
          od_nxt.last = 1'b1;
          od_nxt.line_ready = enter;
        end
      end
      // Move chars up from index i-1 to i, until i reaches end.
      S_SHU: begin
        if (ph_r) begin
          ep.we = 1'b1; ep.waddr = HAW'(i_r); ep.wdata = erd;
          i_nxt = i_r - 1'b1;
        end else if (i_r == end_r) begin
          ep.we = 1'b1; ep.waddr = HAW'(end_r); ep.wdata = ch_r;
          st_nxt = S_OUT;
        end else begin
          ep.raddr = HAW'(i_r - 1'b1); ph_nxt = 1'b1;
        end
      end
      // Move chars down from index i+1 to i, while i < end.
      S_SHD: begin
        if (ph_r) begin
          ep.we = 1'b1; ep.waddr = HAW'(i_r); ep.wdata = erd;
          i_nxt = i_r + 1'b1;
        end else if (i_r >= end_r) begin
          st_nxt = S_OUT;
        end else begin
          ep.raddr = HAW'(i_r + 1'b1); ph_nxt = 1'b1;
        end
      end
      // History slot copied into the edit line.
      S_LOAD: begin
        if (ph_r) begin
          ep.we = 1'b1; ep.waddr = HAW'(i_r); ep.wdata = hrd;
          i_nxt = i_r + 1'b1;
        end else if (i_r >= end_r) begin
          cnt_nxt = end_r; cur_nxt = end_r; st_nxt = S_OUT;
        end else begin
          hp.raddr = haddr(get_r, i_r); ph_nxt = 1'b1;
        end
      end
      // Compare edit line with previous slot, both read together.
      S_CMP: begin
        if (ph_r) begin
          if (erd != hrd) same_nxt = 1'b0;
          i_nxt = i_r + 1'b1;
        end else if (!same_r || i_r >= end_r) begin
          if (same_r) begin
            get_nxt = put_r; back_nxt = '0; st_nxt = S_OUT;
          end else begin
            i_nxt = '0; st_nxt = S_STO;
          end
        end else begin
          ep.raddr = HAW'(i_r); hp.raddr = haddr(pv, i_r); ph_nxt = 1'b1;
        end
      end
      // Store the edit line at the put slot.
      S_STO: begin
        if (ph_r) begin
          hp.we = 1'b1; hp.waddr = haddr(put_r, i_r); hp.wdata = erd;
          i_nxt = i_r + 1'b1;
        end else if (i_r >= end_r) begin
          hwr = 1'b1; hws = put_r; hwl = cnt_r;
          put_nxt = sinc(put_r); get_nxt = sinc(put_r); back_nxt = '0;
          st_nxt = S_OUT;
        end else begin
          ep.raddr = HAW'(i_r); ph_nxt = 1'b1;
        end
      end
      // Enter: read one char, then hand it out as a result.
      S_EMIT: begin
        if (ph_r) begin
          od_nxt = '0;
          od_nxt.line_ready = 1'b1; od_nxt.out_char = erd; od_nxt.char_pos = i_r;
          od_nxt.last = (i_r + 1'b1 == end_r);
          od_nxt.line_length = cnt_r; od_nxt.cursor_pos = cur_r;
          od_nxt.insert_on = ins_r; od_nxt.history_back = back_r;
          ov_nxt = 1'b1; st_nxt = S_EOUT;
        end else begin
          ep.raddr = HAW'(i_r); ph_nxt = 1'b1;
        end
      end
      S_EOUT: begin
        if (!ov_r) begin
          if (i_r + 1'b1 == end_r) st_nxt = S_IDLE;
          else begin i_nxt = i_r + 1'b1; st_nxt = S_EMIT; end
        end
      end
      // Single status result after all updates.
      S_OUT: begin
        od_nxt.line_length = cnt_r; od_nxt.cursor_pos = cur_r;
        od_nxt.insert_on = ins_r; od_nxt.history_back = back_r;
        ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; cur_r <= '0; ins_r <= 1'b1;
      esc_r <= 1'b0; brk_r <= 1'b0; put_r <= '0; get_r <= '0;
      back_r <= '0; ov_r <= 1'b0; ph_r <= 1'b0;
      for (int s = 0; s < tleh_pkg::HistDepth; s++) hlen_r[s] <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; cur_r <= cur_nxt; ins_r <= ins_nxt;
      esc_r <= esc_nxt; brk_r <= brk_nxt; put_r <= put_nxt; get_r <= get_nxt;
      back_r <= back_nxt; ov_r <= ov_nxt; ph_r <= ph_nxt;
      if (hwr) hlen_r[hws] <= hwl;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    i_r <= i_nxt; end_r <= end_nxt; ch_r <= ch_nxt; same_r <= same_nxt;
    od_r <= od_nxt;
  end
endmodule
`default_nettype wire

>>> sv/terminal_line_editor_history_core.sv
// Terminal line editor with history. One item is taken at a time. A plain key
// goes straight to its status result; shifts, history recall, compare and store
// walk the edit line one character at a time through the registered RAM reads.
// Enter gives one result per character, each held until the sink takes it.
// Files: tleh_pkg, tleh_ram, tleh_ctrl.
`default_nettype none
module terminal_line_editor_history_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire tleh_pkg::tleh_in_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      tleh_pkg::tleh_out_t out_data
);
  tleh_pkg::tleh_mem_t ep, hp;
  logic [7:0] erd, hrd;

  tleh_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .ep, .erd, .hp, .hrd
  );

  // Edit line storage.
  tleh_ram #(.Depth(tleh_pkg::LineLen)) u_eram (.clk, .port(ep), .rdata(erd));

  // History ring storage.
  tleh_ram #(.Depth(tleh_pkg::HistDepth * tleh_pkg::LineLen)) u_hram (
    .clk, .port(hp), .rdata(hrd)
  );
endmodule
`default_nettype wire

>>> sv/tleh_checker.sv
// Port-level checker for the line editor, bound to the top level.
// Depends on tleh_pkg and the assertion macro header.
`default_nettype none
`include "terminal_line_editor_history_core_assert.svh"
module tleh_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire tleh_pkg::tleh_in_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire tleh_pkg::tleh_out_t out_data
);
  // Results keep their bounds.
  `TLE_ASSERT_IMP(a_len, clk, rst_n, out_valid, out_data.line_length <= 6'd38 && out_data.cursor_pos <= out_data.line_length, "length or cursor out of range")
  `TLE_ASSERT_IMP(a_back, clk, rst_n, out_valid, out_data.history_back <= 3'd5, "history scroll out of range")
  // No new item while a result waits.
  `TLE_ASSERT_IMP(a_busy, clk, rst_n, out_valid, !in_ready, "input taken while result pending")
  // Stalled result holds.
  `TLE_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
endmodule
bind terminal_line_editor_history_core tleh_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
);
`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the terminal line editor with history.
// Depends on tleh_pkg and terminal_line_editor_history_core; it is the only testbench file.
`timescale 1ns / 1ps
module tb_top;
  import tleh_pkg::*;

  localparam logic [1:0] REQ_NOP = 2'd3;
  localparam int RUN_LIMIT = 2_000_000;
  localparam int LONG_HOLD = 600;

  typedef struct {
    tleh_in_t  item;
    bit        typed;
    tleh_out_t res;
  } key_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  tleh_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tleh_out_t out_data;

  // Shadow copy of the editor state.
  logic [7:0] line_buf [LineLen];
  logic [7:0] hist_buf [HistDepth][LineLen];
  int         hist_len [HistDepth];
  int         n_chars, cur;
  bit         ins_mode, esc_pend, brk_pend;
  int         put_idx, get_idx, back_n;

  tleh_out_t  pending_results[$];
  tleh_in_t   key_stream[$];
  key_row_t   key_rows[$];
  int         mismatches = 0;
  int         results_seen = 0;
  int         cycles = 0;
  bit         feed_done = 1'b0;

  terminal_line_editor_history_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Status fields of a result, taken from the shadow state.
  function automatic tleh_out_t status_of(bit rdy, logic [7:0] ch, int pos, bit fin);
    tleh_out_t r;
    r.line_ready   = rdy;
    r.out_char     = ch;
    r.char_pos     = pos[5:0];
    r.last         = fin;
    r.line_length  = n_chars[5:0];
    r.cursor_pos   = cur[5:0];
    r.insert_on    = ins_mode;
    r.history_back = back_n[2:0];
    return r;
  endfunction

  function automatic void recall_slot();
    int len;
    len = hist_len[get_idx];
    if (len > MaxChars) len = MaxChars;
    if (len != 0) begin
      for (int i = 0; i < len; i++) line_buf[i] = hist_buf[get_idx][i];
      n_chars = len;
      cur = len;
    end
  endfunction

  function automatic void type_char(logic [7:0] ch);
    bit at_end, room;
    at_end = cur >= n_chars;
    room = n_chars < MaxChars;
    if (at_end) begin
      if (room) begin
        line_buf[cur] = ch;
        n_chars++;
        cur++;
      end
      return;
    end
    if (ins_mode && room) begin
      for (int i = n_chars; i > cur; i--) line_buf[i] = line_buf[i-1];
      n_chars++;
    end
    line_buf[cur] = ch;
    cur++;
  endfunction

  // Handles a key with no escape pending; returns 1 for Enter.
  function automatic bit plain_key(logic [7:0] ch);
    case (ch)
      KEY_ESC: begin
        esc_pend = 1'b1;
        brk_pend = 1'b0;
      end
      KEY_ENTER: return 1'b1;
      KEY_DEL: begin
        if (n_chars != 0 && cur < n_chars) begin
          for (int i = cur; i + 1 < n_chars; i++) line_buf[i] = line_buf[i+1];
          n_chars--;
        end
      end
      KEY_BKSPC: begin
        if (cur > 0 && n_chars > 0) begin
          for (int i = cur - 1; i + 1 < n_chars; i++) line_buf[i] = line_buf[i+1];
          n_chars--;
          cur--;
        end
      end
      KEY_CTRL_E: n_chars = cur;
      KEY_CTRL_I: ins_mode = ~ins_mode;
      KEY_CTRL_L: begin
        n_chars = 0;
        cur = 0;
      end
      KEY_CTRL_Z: cur = 0;
      KEY_CTRL_X: cur = n_chars;
      default: if (ch >= KEY_PR_LO && ch < KEY_PR_HI) type_char(ch);
    endcase
    return 1'b0;
  endfunction

  function automatic bit escape_key(logic [7:0] ch);
    if (!brk_pend) begin
      if (ch == KEY_BRACKET) begin
        brk_pend = 1'b1;
        return 1'b0;
      end
      // A stray byte after ESC wipes the line and then counts as a new key.
      esc_pend = 1'b0;
      brk_pend = 1'b0;
      n_chars = 0;
      cur = 0;
      return plain_key(ch);
    end
    case (ch)
      KEY_UP: if (back_n < HistDepth) begin
        get_idx = (get_idx == 0) ? HistDepth - 1 : get_idx - 1;
        recall_slot();
        back_n++;
      end
      KEY_DOWN: if (back_n > 0) begin
        get_idx = (get_idx + 1 >= HistDepth) ? 0 : get_idx + 1;
        recall_slot();
        back_n--;
      end
      KEY_RIGHT: if (cur < n_chars) cur++;
      KEY_LEFT: if (cur > 0) cur--;
      default: ;
    endcase
    esc_pend = 1'b0;
    brk_pend = 1'b0;
    return 1'b0;
  endfunction

  // Stores the line unless it repeats the most recent history entry.
  function automatic void store_line();
    int  prev;
    bit  same;
    prev = (put_idx == 0) ? HistDepth - 1 : put_idx - 1;
    same = hist_len[prev] == n_chars;
    for (int i = 0; i < n_chars; i++)
      if (same && hist_buf[prev][i] != line_buf[i]) same = 1'b0;
    if (!same) begin
      for (int i = 0; i < n_chars; i++) hist_buf[put_idx][i] = line_buf[i];
      hist_len[put_idx] = n_chars;
      put_idx = (put_idx + 1 >= HistDepth) ? 0 : put_idx + 1;
    end
    get_idx = put_idx;
    back_n = 0;
  endfunction

  // Advances the shadow state by one item and queues the results it causes.
  function automatic void predict_editor(tleh_in_t it);
    bit enter;
    enter = 1'b0;
    case (it.req_type)
      REQ_KEY: enter = esc_pend ? escape_key(it.key_byte) : plain_key(it.key_byte);
      REQ_ACCEPT: store_line();
      REQ_CLEAR: begin
        n_chars = 0;
        cur = 0;
      end
      default: ;
    endcase
    if (enter && n_chars != 0) begin
      for (int i = 0; i < n_chars && i < MaxChars; i++)
        pending_results.push_back(status_of(1'b1, line_buf[i], i, i + 1 == n_chars));
    end else begin
      pending_results.push_back(status_of(enter, 8'd0, 0, 1'b1));
    end
  endfunction

  function automatic tleh_in_t mk(logic [1:0] rq, logic [7:0] kb);
    tleh_in_t it;
    it.req_type = rq;
    it.key_byte = kb;
    return it;
  endfunction

  function automatic void add_row(logic [1:0] rq, logic [7:0] kb);
    key_row_t r;
    r.item = mk(rq, kb);
    r.typed = 1'b0;
    r.res = '0;
    key_rows.push_back(r);
  endfunction

  // Row whose single result is written out by hand: an idle line.
  function automatic void add_typed(logic [1:0] rq, logic [7:0] kb, bit rdy, bit ins);
    key_row_t r;
    r.item = mk(rq, kb);
    r.typed = 1'b1;
    r.res = '0;
    r.res.line_ready = rdy;
    r.res.last = 1'b1;
    r.res.insert_on = ins;
    key_rows.push_back(r);
  endfunction

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(KEY_PR_LO, KEY_PR_HI - 1));
  endfunction

  // Random stream: mostly well formed editing, recall and escape sequences.
  function automatic void build_random(int count);
    int pick;
    logic [7:0] ctrl_keys [7];
    ctrl_keys = '{KEY_CTRL_E, KEY_CTRL_I, KEY_CTRL_L, KEY_CTRL_X, KEY_CTRL_Z,
                  KEY_BKSPC, KEY_DEL};
    while (key_stream.size() < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) key_stream.push_back(mk(REQ_KEY, rand_printable()));
      else if (pick < 38) begin
        // Long run of 20 to 42 keys that can fill the line and push past its end.
        repeat ($urandom_range(20, 42)) key_stream.push_back(mk(REQ_KEY, rand_printable()));
      end else if (pick < 52)
        key_stream.push_back(mk(REQ_KEY, ctrl_keys[$urandom_range(0, 6)]));
      else if (pick < 66) begin
        key_stream.push_back(mk(REQ_KEY, KEY_ESC));
        if ($urandom_range(0, 9) != 0) begin
          key_stream.push_back(mk(REQ_KEY, KEY_BRACKET));
          key_stream.push_back(mk(REQ_KEY, ($urandom_range(0, 7) == 0) ? 8'($urandom())
                                           : 8'($urandom_range(KEY_UP, KEY_LEFT))));
        end else key_stream.push_back(mk(REQ_KEY, 8'($urandom())));
      end else if (pick < 74) key_stream.push_back(mk(REQ_KEY, KEY_ENTER));
      else if (pick < 84) key_stream.push_back(mk(REQ_ACCEPT, 8'($urandom())));
      else if (pick < 88) key_stream.push_back(mk(REQ_CLEAR, 8'($urandom())));
      else if (pick < 91) key_stream.push_back(mk(REQ_NOP, 8'($urandom())));
      else key_stream.push_back(mk(REQ_KEY, 8'($urandom())));
    end
  endfunction

  // Offers one item and waits until the block takes it.
  task automatic offer_item(tleh_in_t it, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sender: directed table, then the random stream, then the drain.
  initial begin
    tleh_out_t want;
    bit        burst;
    for (int i = 0; i < LineLen; i++) line_buf[i] = '0;
    for (int s = 0; s < HistDepth; s++) hist_len[s] = 0;
    n_chars = 0; cur = 0; ins_mode = 1'b1; esc_pend = 1'b0; brk_pend = 1'b0;
    put_idx = 0; get_idx = 0; back_n = 0;

    add_typed(REQ_NOP, 8'hFF, 1'b0, 1'b1);
    add_typed(REQ_KEY, KEY_ENTER, 1'b1, 1'b1);
    add_typed(REQ_KEY, KEY_CTRL_I, 1'b0, 1'b0);
    add_typed(REQ_KEY, KEY_CTRL_I, 1'b0, 1'b1);
    add_typed(REQ_CLEAR, 8'h00, 1'b0, 1'b1);
    add_row(REQ_KEY, KEY_PR_LO);
    add_row(REQ_KEY, KEY_PR_HI - 8'd1);
    add_row(REQ_KEY, KEY_PR_HI);
    add_row(REQ_KEY, 8'hFF);
    add_row(REQ_KEY, 8'h00);
    add_row(REQ_KEY, KEY_CTRL_Z);
    add_row(REQ_KEY, "b");
    add_row(REQ_KEY, KEY_CTRL_I);
    add_row(REQ_KEY, "c");
    add_row(REQ_KEY, KEY_CTRL_I);
    add_row(REQ_KEY, KEY_DEL);
    add_row(REQ_KEY, KEY_BKSPC);
    add_row(REQ_KEY, KEY_CTRL_X);
    add_row(REQ_KEY, KEY_ENTER);
    add_row(REQ_ACCEPT, 8'h00);
    add_row(REQ_ACCEPT, 8'hFF);
    add_row(REQ_KEY, KEY_CTRL_L);
    add_row(REQ_KEY, KEY_ESC);
    add_row(REQ_KEY, KEY_BRACKET);
    add_row(REQ_KEY, KEY_UP);
    add_row(REQ_KEY, KEY_ESC);
    add_row(REQ_KEY, "q");
    add_row(REQ_KEY, KEY_ESC);
    add_row(REQ_KEY, KEY_BRACKET);
    add_row(REQ_KEY, "Z");
    add_row(REQ_KEY, KEY_CTRL_Z);
    add_row(REQ_KEY, KEY_CTRL_E);
    build_random(450);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (key_rows[i]) begin
      if (key_rows[i].typed) begin
        predict_editor(key_rows[i].item);
        want = pending_results.pop_back();
        pending_results.push_back(key_rows[i].res);
      end else predict_editor(key_rows[i].item);
      offer_item(key_rows[i].item, 1'b0);
    end
    burst = 1'b0;
    foreach (key_stream[i]) begin
      if (i % 64 == 0) burst = ($urandom_range(0, 2) == 0);
      predict_editor(key_stream[i]);
      offer_item(key_stream[i], burst);
    end
    in_valid <= 1'b0;
    feed_done = 1'b1;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stalls, one long hold-off once results are flowing.
  initial begin
    int  stall;
    bit  held, calm;
    held = 1'b0;
    calm = 1'b0;
    @(posedge clk);
    forever begin
      if (results_seen % 50 == 0) calm = ($urandom_range(0, 2) == 0);
      if (!held && results_seen >= 60) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    tleh_out_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", out_data);
      end else begin
        e = pending_results.pop_front();
        if (out_data.line_ready !== e.line_ready || out_data.out_char !== e.out_char ||
            out_data.char_pos !== e.char_pos || out_data.last !== e.last ||
            out_data.line_length !== e.line_length ||
            out_data.cursor_pos !== e.cursor_pos ||
            out_data.insert_on !== e.insert_on ||
            out_data.history_back !== e.history_back) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("mismatch: expected %p actual %p", e, out_data);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end
endmodule

>>> sim.f
+incdir+sv
sv/tleh_pkg.sv
sv/tleh_ram.sv
sv/tleh_ctrl.sv
sv/terminal_line_editor_history_core.sv
sv/tleh_checker.sv
test/tb_top.sv
